// ----- sv/kcenter_novelty_cache_defines.svh -----
// assertion macros for the novelty cache
`ifndef KCENTER_NOVELTY_CACHE_DEFINES_SVH
`define KCENTER_NOVELTY_CACHE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define KNC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("novelty cache check failed");

// next-cycle implication, checked out of reset
`define KNC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("novelty cache check failed");

`endif

// ----- sv/kcn_pkg.sv -----
// package: sizes, register codes, sequencer states and helpers of the novelty cache
`default_nettype none

package kcn_pkg;

    localparam int MAX_CENTERS = 64;
    localparam int POINT_BITS  = 24;
    localparam int ADDR_W      = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int CNT_W       = $clog2(MAX_CENTERS + 1);
    localparam int LIMIT_W     = 24;
    localparam int CAP_W       = 7;
    localparam int CMP_W       = (POINT_BITS > LIMIT_W) ? POINT_BITS : LIMIT_W;
    localparam int CAPCMP_W    = CAP_W + CNT_W;
    localparam int IN_W        = ((POINT_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 2 + POINT_BITS + 2 * CNT_W;
    localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(167772);
    localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(64);

    localparam logic REG_LIMIT = 1'b0;
    localparam logic REG_CAP   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_INSERT,
        S_OUT
    } t_state;

    function automatic logic [POINT_BITS-1:0] abs_diff(
        input logic [POINT_BITS-1:0] a,
        input logic [POINT_BITS-1:0] b
    );
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

// ----- sv/kcenter_novelty_cache.sv -----
// top level: online 1-d k-center novelty cache with a circular center memory
// an accepted point is compared with every center held, newest first; a hit then gives its result,
// a novel point is inserted before its result, and with eviction the entries newer than the victim
// are first moved up by one over it
// one item at a time: the next word is taken in the idle state after the result is accepted
// reset: synchronous active low, clears occupancy and peak, restores both registers
`default_nettype none
`include "kcenter_novelty_cache_defines.svh"

module kcenter_novelty_cache
    import kcn_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic                i_cfg_index,
    input  wire logic [LIMIT_W-1:0]  i_cfg_data,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [IN_W-1:0]     s_axis_tdata,   // point
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [OUT_W-1:0]         m_axis_tdata    // novel, evicted, evicted_point,
                                                     // occupancy, peak_occupancy
);

    function automatic logic [ADDR_W-1:0] phys(
        input logic [ADDR_W-1:0] base,
        input logic [ADDR_W-1:0] off
    );
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (ADDR_W + 1)'(MAX_CENTERS)) begin
            sum = sum - (ADDR_W + 1)'(MAX_CENTERS);
        end
        return sum[ADDR_W-1:0];
    endfunction

    t_state r_state, n_state;

    logic [LIMIT_W-1:0]    r_limit;
    logic [CAP_W-1:0]      r_cap;
    logic [ADDR_W-1:0]     r_head, n_head;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_peak, n_peak;
    logic [POINT_BITS-1:0] r_point, n_point;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic                  r_rd_vld, n_rd_vld;
    logic [ADDR_W-1:0]     r_rd_off, n_rd_off;
    logic                  r_hit, n_hit;
    logic [POINT_BITS-1:0] r_best_d, n_best_d;
    logic [ADDR_W-1:0]     r_best_off, n_best_off;
    logic [POINT_BITS-1:0] r_best_val, n_best_val;
    logic                  r_mv_vld, n_mv_vld;
    logic [ADDR_W-1:0]     r_mv_addr, n_mv_addr;
    logic                  r_res_novel, n_res_novel;
    logic                  r_res_evicted, n_res_evicted;
    logic [POINT_BITS-1:0] r_res_evpt, n_res_evpt;

    logic [POINT_BITS-1:0] r_mem [MAX_CENTERS];
    logic [POINT_BITS-1:0] r_rd_data;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_wa;
    logic [POINT_BITS-1:0] mem_wd;
    logic [ADDR_W-1:0]     mem_ra;

    logic [POINT_BITS-1:0] cur_dist;
    logic [CNT_W-1:0]      eff_cap;
    logic [ADDR_W-1:0]     head_dec;

    // center memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CNT_W'(1);
        end else if (CAPCMP_W'(r_cap) > CAPCMP_W'(MAX_CENTERS)) begin
            eff_cap = CNT_W'(MAX_CENTERS);
        end else begin
            eff_cap = CNT_W'(r_cap);
        end
    end

    assign cur_dist = abs_diff(r_point, r_rd_data);
    assign head_dec = (r_head == '0) ? ADDR_W'(MAX_CENTERS - 1) : (r_head - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_limit <= LIMIT_RESET;
            r_cap   <= CAP_RESET;
            r_head  <= '0;
            r_count <= '0;
            r_peak  <= '0;
            r_rd_vld <= 1'b0;
            r_mv_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_peak   <= n_peak;
            r_rd_vld <= n_rd_vld;
            r_mv_vld <= n_mv_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_LIMIT: r_limit <= i_cfg_data;
                    REG_CAP:   r_cap   <= i_cfg_data[CAP_W-1:0];
                    default:   r_limit <= r_limit;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_point       <= n_point;
        r_idx         <= n_idx;
        r_rd_off      <= n_rd_off;
        r_hit         <= n_hit;
        r_best_d      <= n_best_d;
        r_best_off    <= n_best_off;
        r_best_val    <= n_best_val;
        r_mv_addr     <= n_mv_addr;
        r_res_novel   <= n_res_novel;
        r_res_evicted <= n_res_evicted;
        r_res_evpt    <= n_res_evpt;
    end

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_count       = r_count;
        n_peak        = r_peak;
        n_point       = r_point;
        n_idx         = r_idx;
        n_rd_vld      = 1'b0;
        n_rd_off      = r_rd_off;
        n_hit         = r_hit;
        n_best_d      = r_best_d;
        n_best_off    = r_best_off;
        n_best_val    = r_best_val;
        n_mv_vld      = 1'b0;
        n_mv_addr     = r_mv_addr;
        n_res_novel   = r_res_novel;
        n_res_evicted = r_res_evicted;
        n_res_evpt    = r_res_evpt;
        mem_we        = 1'b0;
        mem_wa        = r_head;
        mem_wd        = r_point;
        mem_ra        = phys(r_head, r_idx[ADDR_W-1:0]);
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        o_cfg_ready   = 1'b0;

        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                o_cfg_ready   = 1'b1;
                if (s_axis_tvalid) begin
                    n_point       = s_axis_tdata[POINT_BITS-1:0];
                    n_idx         = '0;
                    n_hit         = 1'b0;
                    n_res_novel   = 1'b1;
                    n_res_evicted = 1'b0;
                    n_res_evpt    = '0;
                    n_state       = (r_count == '0) ? S_INSERT : S_SCAN;
                end
            end
            S_SCAN: begin
                // issue reads newest first
                if (r_idx < r_count) begin
                    n_rd_vld = 1'b1;
                    n_rd_off = r_idx[ADDR_W-1:0];
                    n_idx    = r_idx + 1'b1;
                end
                // compare the word read last cycle
                if (r_rd_vld) begin
                    if (CMP_W'(cur_dist) <= CMP_W'(r_limit)) begin
                        n_hit = 1'b1;
                    end
                    if (r_rd_off == '0 || cur_dist < r_best_d) begin
                        n_best_d   = cur_dist;
                        n_best_off = r_rd_off;
                        n_best_val = r_rd_data;
                    end
                end else if (r_idx == r_count) begin
                    if (r_hit) begin
                        n_res_novel = 1'b0;
                        n_state     = S_OUT;
                    end else if (r_count >= eff_cap) begin
                        n_res_evicted = 1'b1;
                        n_res_evpt    = r_best_val;
                        n_idx         = CNT_W'(r_best_off);
                        n_state       = S_SHIFT;
                    end else begin
                        n_state = S_INSERT;
                    end
                end
            end
            S_SHIFT: begin
                // move entries newer than the victim up by one
                if (r_mv_vld) begin
                    mem_we = 1'b1;
                    mem_wa = r_mv_addr;
                    mem_wd = r_rd_data;
                end
                if (r_idx != '0) begin
                    mem_ra    = phys(r_head, r_idx[ADDR_W-1:0] - 1'b1);
                    n_mv_vld  = 1'b1;
                    n_mv_addr = phys(r_head, r_idx[ADDR_W-1:0]);
                    n_idx     = r_idx - 1'b1;
                end else if (!r_mv_vld) begin
                    n_state = S_INSERT;
                end
            end
            S_INSERT: begin
                mem_we = 1'b1;
                if (!r_res_evicted) begin
                    mem_wa  = head_dec;
                    n_head  = head_dec;
                    n_count = r_count + 1'b1;
                    if (r_count + 1'b1 > r_peak) begin
                        n_peak = r_count + 1'b1;
                    end
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign m_axis_tdata = OUT_W'({r_peak, r_count, r_res_evpt, r_res_evicted, r_res_novel});

    `KNC_ASSERT_NOW(a_occ_le_peak, m_axis_tvalid, r_count <= r_peak)
    `KNC_ASSERT_NOW(a_occ_le_max, 1'b1, r_count <= CNT_W'(MAX_CENTERS))
    `KNC_ASSERT_NOW(a_evict_is_novel, m_axis_tvalid && r_res_evicted, r_res_novel)
    `KNC_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

`default_nettype wire

// ----- tb/sv/tb_kcenter_novelty_cache.sv -----
// self-checking testbench for the 1-d k-center novelty cache with a scoreboard predictor
`timescale 1ns / 100ps

module tb_kcenter_novelty_cache
    import kcn_pkg::*;
();

    localparam logic [LIMIT_W-1:0]    EPS_AT_RESET = 24'd167772;
    localparam logic [CAP_W-1:0]      CAP_AT_RESET = 7'd64;
    localparam logic [POINT_BITS-1:0] PT_MAX       = {POINT_BITS{1'b1}};
    localparam int                    ITEM_TARGET  = 1850;
    localparam int                    CYCLE_LIMIT  = 3000000;
    localparam int                    TAIL_CYCLES  = 150;

    typedef struct packed {
        logic                  novel;
        logic                  evicted;
        logic [POINT_BITS-1:0] gone_pt;
        logic [CNT_W-1:0]      occ;
        logic [CNT_W-1:0]      peak;
    } t_verdict;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_valid   = 1'b0;
    logic              i_cfg_index   = REG_LIMIT;
    logic [LIMIT_W-1:0] i_cfg_data   = '0;
    logic              s_axis_tvalid = 1'b0;
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic              m_axis_tready = 1'b0;
    logic              o_cfg_ready;
    logic              s_axis_tready;
    logic              m_axis_tvalid;
    logic [OUT_W-1:0]  m_axis_tdata;

    kcenter_novelty_cache dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [POINT_BITS-1:0] model_centers [MAX_CENTERS];
    int                    model_count = 0;
    int                    model_peak  = 0;
    logic [LIMIT_W-1:0]    eps_reg     = EPS_AT_RESET;
    logic [CAP_W-1:0]      cap_reg     = CAP_AT_RESET;

    logic [POINT_BITS-1:0] point_queue [$];
    logic [POINT_BITS-1:0] recent_pts [$];
    t_verdict              expected_words [$];

    int mismatch_count = 0;
    int words_checked  = 0;
    int hit_count      = 0;
    int novel_count    = 0;
    int evict_count    = 0;
    int items_queued   = 0;
    int phase_count    = 0;
    int cycle_count    = 0;

    function automatic logic [POINT_BITS-1:0] span(input logic [POINT_BITS-1:0] a,
                                                   input logic [POINT_BITS-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic t_verdict novelty_predict(input logic [POINT_BITS-1:0] pt);
        t_verdict              v;
        int                    cap;
        int                    top;
        int                    best;
        logic [POINT_BITS-1:0] best_d;
        v = '0;
        v.novel = 1'b1;
        cap = (cap_reg == 0) ? 1 : ((int'(cap_reg) > MAX_CENTERS) ? MAX_CENTERS : int'(cap_reg));
        for (int i = 0; i < model_count; i++) begin
            if (span(pt, model_centers[i]) <= eps_reg) v.novel = 1'b0;
        end
        if (v.novel) begin
            top = model_count;
            if (model_count >= cap) begin
                best = 0;
                best_d = span(pt, model_centers[0]);
                for (int i = 1; i < model_count; i++) begin
                    if (span(pt, model_centers[i]) < best_d) begin
                        best_d = span(pt, model_centers[i]);
                        best = i;
                    end
                end
                v.evicted = 1'b1;
                v.gone_pt = model_centers[best];
                top = best;
            end else begin
                model_count++;
            end
            for (int i = top; i > 0; i--) begin
                if (i < MAX_CENTERS) model_centers[i] = model_centers[i-1];
            end
            model_centers[0] = pt;
            if (model_count > model_peak) model_peak = model_count;
        end
        v.occ  = CNT_W'(model_count);
        v.peak = CNT_W'(model_peak);
        return v;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 90);
    endfunction

    // points near earlier ones and on the epsilon boundary, plus extremes and noise
    function automatic logic [POINT_BITS-1:0] pick_point();
        longint base;
        longint eps;
        longint v;
        int     r;
        r = $urandom_range(0, 99);
        eps = longint'(eps_reg);
        base = (recent_pts.size() > 0) ?
               longint'(recent_pts[$urandom_range(0, recent_pts.size() - 1)]) : 0;
        if (recent_pts.size() == 0 || r < 30) begin
            v = longint'($urandom) & longint'(PT_MAX);
        end else if (r < 70) begin
            v = base + longint'($urandom_range(0, 2 * eps + 2)) - eps - 1;
        end else if (r < 85) begin
            case ($urandom_range(0, 3))
                0: v = base + eps;
                1: v = base - eps;
                2: v = base + eps + 1;
                default: v = base - eps - 1;
            endcase
        end else if (r < 92) begin
            case ($urandom_range(0, 3))
                0: v = 0;
                1: v = longint'(PT_MAX);
                2: v = 1;
                default: v = longint'(PT_MAX) - 1;
            endcase
        end else begin
            v = longint'(1) << $urandom_range(0, POINT_BITS - 1);
            if ($urandom_range(0, 1)) v = longint'(PT_MAX) - v;
        end
        if (v < 0) v = 0;
        if (v > longint'(PT_MAX)) v = longint'(PT_MAX);
        return v[POINT_BITS-1:0];
    endfunction

    task automatic queue_point(input logic [POINT_BITS-1:0] pt);
        point_queue.push_back(pt);
        recent_pts.push_back(pt);
        if (recent_pts.size() > 64) void'(recent_pts.pop_front());
        items_queued++;
    endtask

    task automatic write_reg(input logic idx, input logic [LIMIT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_LIMIT) eps_reg = val;
        else cap_reg = val[CAP_W-1:0];
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (point_queue.size() != 0 || s_axis_tvalid || expected_words.size() != 0);
    endtask

    task automatic check_field(input string what, input logic [POINT_BITS-1:0] want,
                               input logic [POINT_BITS-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endtask

    // driver
    int  in_gap    = 0;
    int  in_steady = 0;
    always @(posedge i_clk) begin
        logic                  waiting;
        logic                  valid_n;
        logic [POINT_BITS-1:0] pt_n;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            waiting = s_axis_tvalid && !s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                expected_words.push_back(novelty_predict(s_axis_tdata[POINT_BITS-1:0]));
                if (in_steady > 0) begin
                    in_steady--;
                    in_gap = 0;
                end else begin
                    in_gap = idle_len();
                    if ($urandom_range(0, 99) < 2) in_steady = $urandom_range(40, 150);
                end
            end
            if (!waiting) begin
                valid_n = 1'b0;
                pt_n = '0;
                if (in_gap > 0) begin
                    in_gap--;
                end else if (point_queue.size() > 0) begin
                    valid_n = 1'b1;
                    pt_n = point_queue.pop_front();
                end
                s_axis_tvalid <= valid_n;
                if (valid_n) s_axis_tdata <= IN_W'(pt_n);
            end
        end
    end

    // monitor and scoreboard
    int out_stall  = 0;
    int out_steady = 0;
    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_words.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected word expected none got %h", $time, m_axis_tdata);
                end else begin
                    want = expected_words.pop_front();
                    words_checked++;
                    if (!want.novel) hit_count++;
                    else novel_count++;
                    if (want.evicted) evict_count++;
                    check_field("novel", POINT_BITS'(want.novel), POINT_BITS'(m_axis_tdata[0]));
                    check_field("evicted", POINT_BITS'(want.evicted),
                                POINT_BITS'(m_axis_tdata[1]));
                    check_field("evicted_point", want.gone_pt, m_axis_tdata[2 +: POINT_BITS]);
                    check_field("occupancy", POINT_BITS'(want.occ),
                                POINT_BITS'(m_axis_tdata[2 + POINT_BITS +: CNT_W]));
                    check_field("peak_occupancy", POINT_BITS'(want.peak),
                                POINT_BITS'(m_axis_tdata[2 + POINT_BITS + CNT_W +: CNT_W]));
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (out_steady > 0) begin
                    out_steady--;
                end else begin
                    out_stall = idle_len();
                    if ($urandom_range(0, 99) < 1) out_steady = $urandom_range(100, 400);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, expected_words.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int                 cap_hi;
        int                 n;
        int                 r;
        logic [LIMIT_W-1:0] lim;
        logic [CAP_W-1:0]   cap;
        for (int i = 0; i < MAX_CENTERS; i++) model_centers[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty store, extremes, hit exactly at epsilon, just beyond it
        queue_point('0);
        queue_point(PT_MAX);
        queue_point('0);
        queue_point(POINT_BITS'(167772));
        queue_point(POINT_BITS'(167773));
        wait_drained();

        // capacity zero below occupancy, zero epsilon: a repeated point hits, one a step away is novel
        write_reg(REG_LIMIT, '0);
        write_reg(REG_CAP, '0);
        queue_point(POINT_BITS'(5));
        queue_point(POINT_BITS'(86889));
        queue_point(POINT_BITS'(86889));
        queue_point(POINT_BITS'(86890));
        wait_drained();

        // capacity above the maximum, epsilon at full scale hits everything
        write_reg(REG_CAP, LIMIT_W'(127));
        write_reg(REG_LIMIT, PT_MAX);
        queue_point('0);
        queue_point(POINT_BITS'(24'h800000));
        queue_point(PT_MAX);
        wait_drained();

        write_reg(REG_LIMIT, LIMIT_W'(1));
        write_reg(REG_CAP, LIMIT_W'(2));
        queue_point(POINT_BITS'(1));
        queue_point(POINT_BITS'(24'h7FFFFF));
        queue_point(POINT_BITS'(24'hAAAAAA));
        queue_point(POINT_BITS'(24'h555555));
        queue_point(POINT_BITS'(24'hAAAAAB));
        wait_drained();

        while (items_queued < ITEM_TARGET) begin
            phase_count++;
            cap_hi = (6 + 5 * phase_count > MAX_CENTERS) ? MAX_CENTERS : 6 + 5 * phase_count;
            r = $urandom_range(0, 9);
            case (r)
                0: lim = '0;
                1: lim = LIMIT_W'($urandom_range(1, 255));
                2: lim = LIMIT_W'($urandom_range(256, 20000));
                3: lim = EPS_AT_RESET;
                4: lim = LIMIT_W'($urandom_range(20000, 1000000));
                5: lim = LIMIT_W'($urandom);
                6: lim = LIMIT_W'($urandom_range(1 << 20, 1 << 22));
                7: lim = PT_MAX;
                default: lim = LIMIT_W'($urandom_range(1, 5000));
            endcase
            r = $urandom_range(0, 9);
            case (r)
                0: cap = '0;
                1: cap = CAP_W'(127);
                2: cap = CAP_W'(MAX_CENTERS);
                3: cap = CAP_W'($urandom_range(MAX_CENTERS + 1, 127));
                default: cap = CAP_W'($urandom_range(1, cap_hi));
            endcase
            // one phase grows the store at zero epsilon and full capacity, later ones can shrink the capacity under it
            if (phase_count == 10) begin
                lim = '0;
                cap = CAP_W'(127);
            end
            write_reg(REG_LIMIT, lim);
            write_reg(REG_CAP, LIMIT_W'(cap));
            n = $urandom_range(50, 110);
            for (int k = 0; k < n; k++) begin
                if (phase_count == 10) queue_point(POINT_BITS'($urandom));
                else queue_point(pick_point());
            end
            wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("checked %0d words over %0d random phases: %0d hits, %0d novel, %0d evictions",
                 words_checked, phase_count, hit_count, novel_count, evict_count);
        $display("epsilon from zero to full scale, capacity from zero to above the maximum");
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/kcn_pkg.sv
sv/kcenter_novelty_cache.sv
tb/sv/tb_kcenter_novelty_cache.sv
